// ===== rtl/assert_macros.svh =====
// assertion macros shared by the cipher core rtl
// expects clk and arst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define ERTC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error(msg);

// plain invariant outside reset
`define ERTC_INVARIANT(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
	else $error(msg);

`endif

// ===== rtl/ertc_pkg.sv =====
// types, wiring tables and mod-26 helpers for the three rotor cipher core
// no dependencies
`default_nettype none

package ertc_pkg;

	localparam int NLET = 26;
	localparam int LETTER_W = 5;
	localparam int CFG_IDX_W = 2;

	typedef logic [LETTER_W-1:0] letter_t;

	localparam letter_t LETTER_LAST = letter_t'(NLET - 1);

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_START_FAST = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START_MID  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_START_SLOW = 2'd2;

	typedef struct packed {
		letter_t fast;
		letter_t mid;
		letter_t slow;
	} rotor_pos_t;

	// forward wirings
	localparam letter_t FAST_FWD [NLET] = '{
		5'd5, 5'd0, 5'd2, 5'd23, 5'd21, 5'd17, 5'd12, 5'd18, 5'd20, 5'd14, 5'd24, 5'd19, 5'd13,
		5'd8, 5'd7, 5'd3, 5'd11, 5'd4, 5'd6, 5'd22, 5'd9, 5'd10, 5'd15, 5'd16, 5'd25, 5'd1};
	localparam letter_t MID_FWD [NLET] = '{
		5'd10, 5'd2, 5'd11, 5'd16, 5'd12, 5'd18, 5'd22, 5'd7, 5'd19, 5'd9, 5'd3, 5'd13, 5'd21,
		5'd14, 5'd20, 5'd23, 5'd15, 5'd6, 5'd5, 5'd0, 5'd1, 5'd4, 5'd24, 5'd17, 5'd25, 5'd8};
	localparam letter_t SLOW_FWD [NLET] = '{
		5'd10, 5'd19, 5'd13, 5'd14, 5'd17, 5'd6, 5'd16, 5'd11, 5'd5, 5'd3, 5'd21, 5'd15, 5'd23,
		5'd22, 5'd2, 5'd4, 5'd8, 5'd24, 5'd12, 5'd20, 5'd25, 5'd18, 5'd9, 5'd0, 5'd7, 5'd1};
	localparam letter_t REFL [NLET] = '{
		5'd8, 5'd11, 5'd22, 5'd25, 5'd5, 5'd4, 5'd18, 5'd23, 5'd0, 5'd14, 5'd20, 5'd1, 5'd17,
		5'd24, 5'd9, 5'd21, 5'd19, 5'd12, 5'd6, 5'd16, 5'd10, 5'd15, 5'd2, 5'd7, 5'd13, 5'd3};

	// inverse wirings
	localparam letter_t FAST_INV [NLET] = '{
		5'd1, 5'd25, 5'd2, 5'd15, 5'd17, 5'd0, 5'd18, 5'd14, 5'd13, 5'd20, 5'd21, 5'd16, 5'd6,
		5'd12, 5'd9, 5'd22, 5'd23, 5'd5, 5'd7, 5'd11, 5'd8, 5'd4, 5'd19, 5'd3, 5'd10, 5'd24};
	localparam letter_t MID_INV [NLET] = '{
		5'd19, 5'd20, 5'd1, 5'd10, 5'd21, 5'd18, 5'd17, 5'd7, 5'd25, 5'd9, 5'd0, 5'd2, 5'd4,
		5'd11, 5'd13, 5'd16, 5'd3, 5'd23, 5'd5, 5'd8, 5'd14, 5'd12, 5'd6, 5'd15, 5'd22, 5'd24};
	localparam letter_t SLOW_INV [NLET] = '{
		5'd23, 5'd25, 5'd14, 5'd9, 5'd15, 5'd8, 5'd5, 5'd24, 5'd16, 5'd22, 5'd0, 5'd7, 5'd18,
		5'd2, 5'd3, 5'd11, 5'd6, 5'd4, 5'd21, 5'd1, 5'd19, 5'd10, 5'd13, 5'd12, 5'd17, 5'd20};

	function automatic letter_t mod26(input letter_t v);
		logic [LETTER_W:0] d;
		d = {1'b0, v} - (LETTER_W+1)'(NLET);
		return d[LETTER_W] ? v : d[LETTER_W-1:0];
	endfunction

	function automatic letter_t add26(input letter_t a, input letter_t b);
		logic [LETTER_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= (LETTER_W+1)'(NLET))
			s = s - (LETTER_W+1)'(NLET);
		return s[LETTER_W-1:0];
	endfunction

	function automatic letter_t sub26(input letter_t a, input letter_t b);
		logic [LETTER_W:0] d;
		d = {1'b0, a} - {1'b0, b};
		if (d[LETTER_W])
			d = d + (LETTER_W+1)'(NLET);
		return d[LETTER_W-1:0];
	endfunction

	function automatic letter_t inc26(input letter_t a);
		return (a == LETTER_LAST) ? '0 : a + letter_t'(1);
	endfunction

endpackage

`default_nettype wire

// ===== rtl/ertc_scrambler.sv =====
// letter path through the three rotors, the reflector and back
// depends on ertc_pkg
`default_nettype none

module ertc_scrambler (
	input  wire ertc_pkg::letter_t    letter,
	input  wire ertc_pkg::rotor_pos_t pos,
	output ertc_pkg::letter_t         cipher
);
	import ertc_pkg::*;

	letter_t f1, f2, f3, r, b3, b2;

	always_comb begin
		f1 = FAST_FWD[sub26(letter, pos.fast)];
		f2 = MID_FWD[sub26(f1, pos.mid)];
		f3 = SLOW_FWD[sub26(f2, pos.slow)];
		r = REFL[f3];
		b3 = add26(SLOW_INV[r], pos.slow);
		b2 = add26(MID_INV[b3], pos.mid);
		cipher = add26(FAST_INV[b2], pos.fast);
	end

endmodule

`default_nettype wire

// ===== rtl/ertc_stepper.sv =====
// start offset registers, rotor offsets and step counters
// depends on ertc_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module ertc_stepper (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        cfg_we,
	input  wire [ertc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire ertc_pkg::letter_t     cfg_data,
	input  wire                        take,
	input  wire                        restart,
	output ertc_pkg::rotor_pos_t       pos
);
	import ertc_pkg::*;

	letter_t start_fast_q, start_mid_q, start_slow_q;
	letter_t fast_offset_q, mid_offset_q, slow_offset_q;
	letter_t fast_steps_q, mid_steps_q;
	letter_t fsteps, msteps;
	rotor_pos_t pos_next;
	letter_t fsteps_next, msteps_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_fast_q <= '0;
			start_mid_q  <= '0;
			start_slow_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_START_FAST: start_fast_q <= cfg_data;
				REG_START_MID:  start_mid_q  <= cfg_data;
				REG_START_SLOW: start_slow_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// offsets seen by the letter in this transfer
	always_comb begin
		if (restart) begin
			pos.fast = mod26(start_fast_q);
			pos.mid  = mod26(start_mid_q);
			pos.slow = mod26(start_slow_q);
			fsteps = '0;
			msteps = '0;
		end else begin
			pos.fast = fast_offset_q;
			pos.mid  = mid_offset_q;
			pos.slow = slow_offset_q;
			fsteps = fast_steps_q;
			msteps = mid_steps_q;
		end
	end

	always_comb begin
		pos_next = pos;
		pos_next.fast = inc26(pos.fast);
		fsteps_next = fsteps + letter_t'(1);
		msteps_next = msteps;
		if (fsteps == LETTER_LAST) begin
			fsteps_next = '0;
			pos_next.mid = inc26(pos.mid);
			msteps_next = msteps + letter_t'(1);
			if (msteps == LETTER_LAST) begin
				msteps_next = '0;
				pos_next.slow = inc26(pos.slow);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fast_offset_q <= '0;
			mid_offset_q  <= '0;
			slow_offset_q <= '0;
			fast_steps_q  <= '0;
			mid_steps_q   <= '0;
		end else if (take) begin
			fast_offset_q <= pos_next.fast;
			mid_offset_q  <= pos_next.mid;
			slow_offset_q <= pos_next.slow;
			fast_steps_q  <= fsteps_next;
			mid_steps_q   <= msteps_next;
		end
	end

	`ERTC_INVARIANT(a_state_range, fast_offset_q <= LETTER_LAST && mid_offset_q <= LETTER_LAST && slow_offset_q <= LETTER_LAST && fast_steps_q <= LETTER_LAST && mid_steps_q <= LETTER_LAST, "rotor state out of range")
	`ERTC_ASSERT(a_mid_holds, (take && !restart && fast_steps_q != LETTER_LAST) |=> $stable(mid_offset_q), "middle rotor stepped early")
	`ERTC_ASSERT(a_idle_holds, !take |=> $stable(fast_offset_q) && $stable(slow_offset_q), "rotor moved without a transfer")

endmodule

`default_nettype wire

// ===== rtl/three_rotor_enigma_cipher_core.sv =====
// Three rotor letter cipher core: one letter per transfer in, its ciphered letter out.
// A result passes the input stage and then the result stage register before it is offered; the core
// sustains one letter per cycle while the result stage is not stalled. That rate is set by the rotor
// stepping logic, which settles the offsets for a letter in the same cycle it is transferred. Letters
// are 0 for A to 25 for Z, values above 25 are taken mod 26. Setting restart with a letter
// loads the start offsets from the registers (start_fast, start_mid, start_slow at indexes
// 0 to 2, taken mod 26) and clears the step counters before that letter is ciphered. Write
// registers only while idle.
// depends on ertc_pkg, ertc_stepper, ertc_scrambler and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module three_rotor_enigma_cipher_core (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           cfg_we,
	input  wire [ertc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire ertc_pkg::letter_t        cfg_data,
	input  wire                           letter_valid,
	output logic                          letter_ready,
	input  wire ertc_pkg::letter_t        letter,
	input  wire                           restart,
	output logic                          cipher_valid,
	input  wire                           cipher_ready,
	output ertc_pkg::letter_t             cipher_letter
);
	import ertc_pkg::*;

	logic       take;
	logic       out_free;
	rotor_pos_t pos;
	logic       valid_s1;
	letter_t    letter_s1;
	rotor_pos_t pos_s1;
	letter_t    cipher;
	logic       cipher_valid_s2;
	letter_t    cipher_letter_s2;

	assign out_free     = !cipher_valid_s2 || cipher_ready;
	assign letter_ready = !valid_s1 || out_free;
	assign take         = letter_valid && letter_ready;

	ertc_stepper u_stepper (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.take      (take),
		.restart   (restart),
		.pos       (pos)
	);

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (letter_ready) begin
			valid_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			letter_s1 <= mod26(letter);
			pos_s1    <= pos;
		end
	end

	ertc_scrambler u_scrambler (
		.letter (letter_s1),
		.pos    (pos_s1),
		.cipher (cipher)
	);

	// result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cipher_valid_s2 <= 1'b0;
		end else if (out_free) begin
			cipher_valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s1) begin
			cipher_letter_s2 <= cipher;
		end
	end

	assign cipher_valid  = cipher_valid_s2;
	assign cipher_letter = cipher_letter_s2;

	`ERTC_ASSERT(a_s1_moves, (valid_s1 && out_free) |=> cipher_valid_s2, "letter lost between stages")
	`ERTC_ASSERT(a_stall_cause, !letter_ready |-> (valid_s1 && cipher_valid_s2 && !cipher_ready), "input stalled with room")
	`ERTC_INVARIANT(a_result_range, !cipher_valid_s2 || cipher_letter_s2 <= LETTER_LAST, "result letter out of range")

endmodule

`default_nettype wire

// ===== verif/three_rotor_enigma_cipher_core_test.sv =====
// self-checking testbench for three_rotor_enigma_cipher_core: letters with random restarts,
// register settings at the extremes and random back-pressure, checked against an internal rotor
// model. depends on ertc_pkg and the cipher core rtl
`timescale 1ns / 100ps

module three_rotor_enigma_cipher_core_test;
	import ertc_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 150;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	typedef enum int {ROTOR_FAST = 0, ROTOR_MID = 1, ROTOR_SLOW = 2} rotor_e;
	typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_PATTERN, RX_SPARSE} rx_mode_e;

	typedef struct packed {
		letter_t value;
		logic    reload;
	} letter_item_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	letter_t cfg_data;
	logic letter_valid;
	logic letter_ready;
	letter_t letter;
	logic restart;
	logic cipher_valid;
	logic cipher_ready;
	letter_t cipher_letter;

	three_rotor_enigma_cipher_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.letter_valid(letter_valid),
		.letter_ready(letter_ready),
		.letter(letter),
		.restart(restart),
		.cipher_valid(cipher_valid),
		.cipher_ready(cipher_ready),
		.cipher_letter(cipher_letter)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// rotor wirings and reflector
	int wiring [3][26] = '{
		'{5, 0, 2, 23, 21, 17, 12, 18, 20, 14, 24, 19, 13,
		  8, 7, 3, 11, 4, 6, 22, 9, 10, 15, 16, 25, 1},
		'{10, 2, 11, 16, 12, 18, 22, 7, 19, 9, 3, 13, 21,
		  14, 20, 23, 15, 6, 5, 0, 1, 4, 24, 17, 25, 8},
		'{10, 19, 13, 14, 17, 6, 16, 11, 5, 3, 21, 15, 23,
		  22, 2, 4, 8, 24, 12, 20, 25, 18, 9, 0, 7, 1}};
	int reflector [26] = '{8, 11, 22, 25, 5, 4, 18, 23, 0, 14, 20, 1, 17,
		24, 9, 21, 19, 12, 6, 16, 10, 15, 2, 7, 13, 3};

	// rotor state mirror
	rotor_pos_t start_pos;
	rotor_pos_t rotor;
	logic [4:0] fast_steps;
	logic [4:0] mid_steps;

	letter_item_t pending_letters[$];
	letter_t expected_cipher[$];

	int errors = 0;
	int letters_sent = 0;
	int restarts_sent = 0;
	int results_checked = 0;
	int reg_writes = 0;
	int slow_steps_seen = 0;
	int cycle_count = 0;

	function automatic int rotor_forward(input rotor_e r, input int x, input letter_t k);
		return wiring[r][(x + NLET - int'(k)) % NLET];
	endfunction

	function automatic int rotor_backward(input rotor_e r, input int t, input letter_t k);
		int p;
		p = 0;
		for (int i = 0; i < NLET; i++)
			if (wiring[r][i] == t)
				p = i;
		return (p + int'(k)) % NLET;
	endfunction

	function automatic letter_t encipher(input letter_t raw, input logic reload);
		int x;
		if (reload) begin
			rotor.fast = letter_t'(int'(start_pos.fast) % NLET);
			rotor.mid = letter_t'(int'(start_pos.mid) % NLET);
			rotor.slow = letter_t'(int'(start_pos.slow) % NLET);
			fast_steps = '0;
			mid_steps = '0;
		end
		x = int'(raw) % NLET;
		x = rotor_forward(ROTOR_FAST, x, rotor.fast);
		x = rotor_forward(ROTOR_MID, x, rotor.mid);
		x = rotor_forward(ROTOR_SLOW, x, rotor.slow);
		x = reflector[x];
		x = rotor_backward(ROTOR_SLOW, x, rotor.slow);
		x = rotor_backward(ROTOR_MID, x, rotor.mid);
		x = rotor_backward(ROTOR_FAST, x, rotor.fast);
		// step after the letter
		rotor.fast = letter_t'((int'(rotor.fast) + 1) % NLET);
		fast_steps = fast_steps + 5'd1;
		if (int'(fast_steps) >= NLET) begin
			fast_steps = '0;
			rotor.mid = letter_t'((int'(rotor.mid) + 1) % NLET);
			mid_steps = mid_steps + 5'd1;
			if (int'(mid_steps) >= NLET) begin
				mid_steps = '0;
				rotor.slow = letter_t'((int'(rotor.slow) + 1) % NLET);
				slow_steps_seen++;
			end
		end
		return letter_t'(x);
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("ERROR t=%0t %s: got %0d expected %0d", $time, what, got, want);
		errors++;
	endtask

	// input side: bursts of transfers with random gaps
	int burst_left = 1;
	int gap_left = 0;

	always @(posedge clk) begin : sender
		logic next_valid;
		letter_item_t item;
		if (arst_n) begin
			next_valid = letter_valid;
			if (letter_valid && letter_ready) begin
				expected_cipher.push_back(encipher(letter, restart));
				letters_sent++;
				if (restart)
					restarts_sent++;
				next_valid = 1'b0;
			end
			if (!next_valid) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_letters.size() > 0) begin
					item = pending_letters.pop_front();
					letter <= item.value;
					restart <= item.reload;
					next_valid = 1'b1;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 24);
						gap_left = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
					end
				end
			end
			letter_valid <= next_valid;
		end
	end

	// output side: stall pattern picked at random from four modes, plus long holds
	rx_mode_e rx_mode = RX_ALWAYS;
	int rx_cycle = 0;
	int hold_left = 0;
	int next_hold_at = 250;

	always @(posedge clk) begin : receiver
		if (arst_n) begin
			rx_cycle++;
			if (rx_cycle % 64 == 0)
				rx_mode = rx_mode_e'($urandom_range(0, 3));
			if (results_checked >= next_hold_at) begin
				hold_left = HOLD_CYCLES;
				next_hold_at += 850;
			end
			if (hold_left > 0) begin
				hold_left--;
				cipher_ready <= 1'b0;
			end else begin
				case (rx_mode)
					RX_ALWAYS: cipher_ready <= 1'b1;
					RX_RANDOM: cipher_ready <= 1'($urandom_range(0, 1));
					RX_PATTERN: cipher_ready <= (rx_cycle % 4 != 3);
					default: cipher_ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin : monitor
		letter_t want;
		if (arst_n && cipher_valid && cipher_ready) begin
			if (expected_cipher.size() == 0) begin
				report_mismatch("cipher transfer with nothing expected", int'(cipher_letter), 0);
			end else begin
				want = expected_cipher.pop_front();
				results_checked++;
				if (cipher_letter !== want)
					report_mismatch("cipher_letter", int'(cipher_letter), int'(want));
			end
		end
	end

	always @(posedge clk) begin : watchdog
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				expected_cipher.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic queue_letter(input int value, input logic reload);
		letter_item_t item;
		item.value = letter_t'(value);
		item.reload = reload;
		pending_letters.push_back(item);
	endtask

	task automatic wait_idle();
		while (pending_letters.size() > 0 || letter_valid || expected_cipher.size() > 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= letter_t'(value);
		reg_writes++;
		case (idx)
			REG_START_FAST: start_pos.fast = letter_t'(value);
			REG_START_MID: start_pos.mid = letter_t'(value);
			REG_START_SLOW: start_pos.slow = letter_t'(value);
			default: ;
		endcase
	endtask

	task automatic write_starts(input int f, input int m, input int s);
		write_reg(REG_START_FAST, f);
		write_reg(REG_START_MID, m);
		write_reg(REG_START_SLOW, s);
		// unused index must not disturb anything
		write_reg(REG_UNUSED, $urandom_range(0, 31));
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	int phase_len [5] = '{200, 800, 300, 300, 350};

	initial begin : stimulus
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		letter_valid = 1'b0;
		letter = '0;
		restart = 1'b0;
		cipher_ready = 1'b0;
		start_pos = '0;
		rotor = '0;
		fast_steps = '0;
		mid_steps = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// before any restart, offsets start from zero; letters above Z wrap
		queue_letter(0, 1'b0);
		queue_letter(25, 1'b0);
		queue_letter(26, 1'b0);
		queue_letter(31, 1'b0);
		queue_letter(13, 1'b0);
		wait_idle();

		write_starts(25, 25, 25);
		queue_letter(0, 1'b1);
		queue_letter(25, 1'b0);
		queue_letter(31, 1'b0);
		queue_letter(7, 1'b0);
		queue_letter(31, 1'b1);
		queue_letter(0, 1'b0);
		wait_idle();

		// start values above 25 wrap on restart
		write_starts(31, 26, 30);
		queue_letter(12, 1'b1);
		queue_letter(25, 1'b0);
		queue_letter(26, 1'b0);
		queue_letter(0, 1'b1);
		queue_letter(31, 1'b1);
		wait_idle();

		write_starts(0, 0, 0);
		queue_letter(25, 1'b1);
		queue_letter(0, 1'b0);
		queue_letter(30, 1'b0);
		queue_letter(16, 1'b1);
		wait_idle();

		// random phases, one long run past a slow rotor step
		for (int p = 0; p < 5; p++) begin
			case (p)
				0: write_starts(0, 0, 0);
				2: write_starts(25, 25, 25);
				default: write_starts($urandom_range(0, 31), $urandom_range(0, 31),
					$urandom_range(0, 31));
			endcase
			for (int i = 0; i < phase_len[p]; i++) begin
				if (i == 0)
					queue_letter($urandom_range(0, 31), p != 2);
				else if (p == 1)
					queue_letter($urandom_range(0, 31), 1'b0);
				else
					queue_letter($urandom_range(0, 31), $urandom_range(0, 59) == 0);
			end
			wait_idle();
		end

		repeat (10) @(posedge clk);
		$display("covered %0d letters (%0d with restart) and %0d register writes",
			letters_sent, restarts_sent, reg_writes);
		$display("%0d ciphered letters checked, %0d slow rotor steps", results_checked,
			slow_steps_seen);
		if (errors == 0 && expected_cipher.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
